// ===== hdl/poisson_gauss_seidel_solver_top_defines.svh =====
// Assertion helpers for the solver block.
`ifndef POISSON_GAUSS_SEIDEL_SOLVER_TOP_DEFINES_SVH
`define POISSON_GAUSS_SEIDEL_SOLVER_TOP_DEFINES_SVH

// Implication checked every clock, quiet during reset.
`define PGS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset.
`define PGS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pgs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pgs_pkg;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_SOLVE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] REG_GRID_SIZE   = 2'd0;
    localparam logic [1:0] REG_H_SQUARED   = 2'd1;
    localparam logic [1:0] REG_TOLERANCE   = 2'd2;
    localparam logic [1:0] REG_SWEEP_LIMIT = 2'd3;

    localparam int CHANGE_WIDTH = 31;
    localparam int COUNT_WIDTH  = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SWEEP_START,
        ST_FETCH_C,
        ST_FETCH_U,
        ST_FETCH_D,
        ST_FETCH_L,
        ST_FETCH_R,
        ST_MUL,
        ST_SUM,
        ST_WRITE,
        ST_SWEEP_END,
        ST_RESULT
    } pgs_state_t;

    // Datapath commands from the controller.
    typedef struct packed {
        logic load_wr;     // write both stores from input transaction
        logic read_cap;    // capture read cell into output
        logic solve_init;  // clear sweep count
        logic sweep_init;  // cursor to (1,1), clear worst change
        logic [2:0] rd_sel;// which cell to address: 0 C,1 U,2 D,3 L,4 R
        logic cap_sel;     // capture the data just read (registered read)
        logic do_mul;      // multiply step; product is registered at centre capture
        logic do_sum;      // register new value
        logic do_write;    // write back, update worst, advance cursor
        logic sweep_done;  // bump sweep count
        logic finish;      // latch status
        logic solve_out;   // output from solve (cell zero)
    } pgs_cmd_t;

    typedef struct packed {
        logic last_cell;   // cursor on last interior cell
        logic keep_going;  // worst > tol and count < limit
    } pgs_stat_t;

endpackage
`default_nettype wire

// ===== hdl/pgs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pgs_ctrl
    import pgs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    input  wire logic [1:0] in_kind,
    input  wire logic       out_free,
    input  wire pgs_stat_t  stat,
    output logic            in_ready,
    output logic            out_load,
    output pgs_cmd_t        cmd
);
    pgs_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    case (in_kind)
                        KIND_LOAD:  cmd.load_wr = 1'b1;
                        KIND_SOLVE: begin
                            cmd.solve_init = 1'b1;
                            state_next = ST_SWEEP_START;
                        end
                        KIND_READ:  state_next = ST_READ;
                        default:    ;
                    endcase
                end
            end
            ST_READ: begin
                // store data valid now
                if (out_free) begin
                    cmd.read_cap = 1'b1;
                    out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP_START: begin
                cmd.sweep_init = 1'b1;
                state_next = ST_FETCH_C;
            end
            ST_FETCH_C: begin
                cmd.rd_sel = 3'd0;
                state_next = ST_FETCH_U;
            end
            ST_FETCH_U: begin
                cmd.rd_sel = 3'd1; cmd.cap_sel = 1'b1;
                state_next = ST_FETCH_D;
            end
            ST_FETCH_D: begin
                cmd.rd_sel = 3'd2; cmd.cap_sel = 1'b1;
                state_next = ST_FETCH_L;
            end
            ST_FETCH_L: begin
                cmd.rd_sel = 3'd3; cmd.cap_sel = 1'b1;
                state_next = ST_FETCH_R;
            end
            ST_FETCH_R: begin
                cmd.rd_sel = 3'd4; cmd.cap_sel = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.cap_sel = 1'b1; cmd.do_mul = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.do_sum = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                cmd.do_write = 1'b1;
                state_next = stat.last_cell ? ST_SWEEP_END : ST_FETCH_C;
            end
            ST_SWEEP_END: begin
                cmd.sweep_done = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (stat.keep_going) begin
                    state_next = ST_SWEEP_START;
                end else if (out_free) begin
                    cmd.finish = 1'b1;
                    cmd.solve_out = 1'b1;
                    out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== hdl/pgs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pgs_datapath
    import pgs_pkg::*;
#(
    parameter int GRID_MAX    = 128,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire pgs_cmd_t                      cmd,
    input  wire logic                          in_fire,
    input  wire logic [$clog2(GRID_MAX)-1:0]   in_row,
    input  wire logic [$clog2(GRID_MAX)-1:0]   in_col,
    input  wire logic signed [31:0]            in_u,
    input  wire logic signed [31:0]            in_f,
    input  wire logic [7:0]                    cfg_grid_size,
    input  wire logic [31:0]                   cfg_h_squared,
    input  wire logic [CHANGE_WIDTH-1:0]       cfg_tolerance,
    input  wire logic [COUNT_WIDTH-1:0]        cfg_sweep_limit,
    output pgs_stat_t                          stat,
    output logic signed [31:0]                 rd_cell,
    output logic [COUNT_WIDTH-1:0]             st_count,
    output logic                               st_conv,
    output logic [CHANGE_WIDTH-1:0]            st_change
);
    localparam int AW    = $clog2(GRID_MAX);
    localparam int DEPTH = GRID_MAX * GRID_MAX;
    localparam int VW    = VALUE_WIDTH;
    localparam int SW    = VW + 4;
    localparam logic signed [SW-1:0] VMAX = SW'((64'sd1 <<< (VW - 1)) - 1);
    localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);
    localparam logic [31:0] CHMAX = 32'h7FFF_FFFF;

    logic signed [VW-1:0] u_mem [DEPTH];
    logic signed [VW-1:0] f_mem [DEPTH];

    logic [AW-1:0] r_reg, c_reg;
    logic [AW-1:0] last_reg;
    logic [2*AW-1:0] waddr, raddr;
    logic signed [VW-1:0] u_rd_reg, f_rd_reg;
    logic signed [VW-1:0] old_reg;
    logic signed [SW-1:0] acc_reg;
    logic signed [VW+33:0] prod_reg;
    logic signed [VW-1:0] new_reg;
    logic [2:0] cap_idx_reg;
    logic [CHANGE_WIDTH-1:0] worst_reg;
    logic [COUNT_WIDTH-1:0] count_reg, status_count_reg;
    logic conv_reg;
    logic [CHANGE_WIDTH-1:0] change_reg;
    logic inside_reg;
    logic signed [VW-1:0] in_u_s, in_f_s;

    // effective grid bound, clamped to 3..GRID_MAX
    logic [10:0] n_eff;
    always_comb begin
        n_eff = {3'd0, cfg_grid_size};
        if (cfg_grid_size < 8'd3) n_eff = 11'd3;
        if ({3'd0, cfg_grid_size} > 11'(GRID_MAX)) n_eff = 11'(GRID_MAX);
    end

    function automatic logic signed [VW-1:0] sat32(input logic signed [31:0] x);
        logic signed [63:0] w;
        logic signed [63:0] hi;
        w  = 64'(x);
        hi = (64'sd1 <<< (VW - 1)) - 1;
        if (w > hi) return VW'(hi);
        if (w < -hi - 1) return VW'(-hi - 1);
        return VW'(w);
    endfunction

    assign in_u_s = sat32(in_u);
    assign in_f_s = sat32(in_f);

    always_comb begin
        case (cmd.rd_sel)
            3'd1:    raddr = {r_reg - AW'(1), c_reg};
            3'd2:    raddr = {r_reg + AW'(1), c_reg};
            3'd3:    raddr = {r_reg, c_reg - AW'(1)};
            3'd4:    raddr = {r_reg, c_reg + AW'(1)};
            default: raddr = {r_reg, c_reg};
        endcase
        if (in_fire) raddr = {in_row, in_col};
    end
    assign waddr = in_fire ? {in_row, in_col} : {r_reg, c_reg};

    // stores: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if ((in_fire && cmd.load_wr) || cmd.do_write) begin
            u_mem[waddr] <= cmd.do_write ? new_reg : in_u_s;
        end
        if (in_fire && cmd.load_wr) f_mem[waddr] <= in_f_s;
        u_rd_reg <= u_mem[raddr];
        f_rd_reg <= f_mem[raddr];
    end

    logic signed [SW-1:0] sum_w, q_w;
    logic signed [VW+33:0] term_w;
    logic signed [VW:0] d_w;
    logic [VW:0] ad_w;
    logic [CHANGE_WIDTH-1:0] ad_sat;

    assign term_w = (prod_reg + (VW+34)'(64'sd2147483648)) >>> 32;
    assign sum_w  = acc_reg - SW'(term_w);
    assign q_w    = (sum_w + SW'(2)) >>> 2;
    assign d_w    = (VW+1)'(new_reg) - (VW+1)'(old_reg);
    assign ad_w   = d_w[VW] ? (VW+1)'(-d_w) : (VW+1)'(d_w);
    assign ad_sat = ((VW+1 > 31) && (64'(ad_w) > 64'(CHMAX))) ? CHANGE_WIDTH'(CHMAX)
                                                                : CHANGE_WIDTH'(ad_w);

    always_ff @(posedge aclk) begin
        cap_idx_reg <= cmd.rd_sel;
        if (cmd.cap_sel) begin
            if (cap_idx_reg == 3'd0) begin
                old_reg <= u_rd_reg;
                acc_reg <= '0;
                prod_reg <= $signed({1'b0, cfg_h_squared}) * f_rd_reg;
            end else begin
                acc_reg <= acc_reg + SW'(u_rd_reg);
            end
        end
        if (cmd.do_sum) begin
            if (q_w > VMAX)      new_reg <= VW'(VMAX);
            else if (q_w < VMIN) new_reg <= VW'(VMIN);
            else                 new_reg <= VW'(q_w);
        end
        if (cmd.read_cap) rd_cell <= inside_reg ? 32'(u_rd_reg) : '0;
        if (cmd.solve_out) rd_cell <= '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_reg <= '0; c_reg <= '0; last_reg <= '0;
            worst_reg <= '0; count_reg <= '0;
            status_count_reg <= '0; conv_reg <= 1'b0; change_reg <= '0;
            inside_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                inside_reg <= 1'b1;
                // cursor holds the read address while a read waits for the output
                r_reg <= in_row; c_reg <= in_col;
            end
            if (cmd.solve_init) count_reg <= '0;
            if (cmd.sweep_init) begin
                r_reg <= AW'(1); c_reg <= AW'(1);
                last_reg <= AW'(n_eff - 11'd2);
                worst_reg <= '0;
            end
            if (cmd.do_write) begin
                if (ad_sat > worst_reg) worst_reg <= ad_sat;
                if (c_reg == last_reg) begin
                    c_reg <= AW'(1); r_reg <= r_reg + AW'(1);
                end else begin
                    c_reg <= c_reg + AW'(1);
                end
            end
            if (cmd.sweep_done) count_reg <= count_reg + COUNT_WIDTH'(1);
            if (cmd.finish) begin
                status_count_reg <= count_reg;
                conv_reg <= (worst_reg <= cfg_tolerance);
                change_reg <= worst_reg;
            end
        end
    end

    logic [COUNT_WIDTH-1:0] lim;
    assign lim = (cfg_sweep_limit == '0) ? COUNT_WIDTH'(1) : cfg_sweep_limit;
    assign stat.last_cell  = (c_reg == last_reg) && (r_reg == last_reg);
    assign stat.keep_going = (worst_reg > cfg_tolerance) && (count_reg < lim);
    assign st_count  = status_count_reg;
    assign st_conv   = conv_reg;
    assign st_change = change_reg;
endmodule
`default_nettype wire

// ===== hdl/poisson_gauss_seidel_solver_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Gauss-Seidel Poisson solver, 5-point stencil, signed Q11.20 values.
// Input channel s_*: kind 0 loads a cell (u and f), kind 1 runs a solve,
// kind 2 reads a cell; kind 3 is dropped. Loads give no result transaction.
// Result channel m_*: one transaction per solve or read, carrying the cell
// (zero for a solve) and the status of the last solve.
// A load writes the stores on acceptance; a read passes the registered
// store read to the output register. A solve updates each interior cell
// with five reads of the single-port solution store, then multiply, sum
// and write-back; sweeps repeat until the change is within tolerance or the
// sweep limit is reached. Only one transaction is in work at a time.
// Configuration: cfg_we/cfg_index/cfg_data, written while the block is idle.
// Reset (aresetn low, synchronous) restores register defaults and clears
// the status; grid stores keep undefined contents until loaded.
// A stalled receiver holds m_valid and the payload; the block then waits
// before loading the next result, yet still accepts transactions when idle.
module poisson_gauss_seidel_solver_top
    import pgs_pkg::*;
#(
    parameter int GRID_MAX    = 128,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [1:0]              s_kind,
    input  wire logic [6:0]              s_row,
    input  wire logic [6:0]              s_col,
    input  wire logic signed [31:0]      s_u_value,
    input  wire logic signed [31:0]      s_f_value,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [31:0]           m_cell_value,
    output logic [15:0]                  m_sweep_count,
    output logic                         m_converged,
    output logic [30:0]                  m_final_change,
    input  wire logic                    cfg_we,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [31:0]             cfg_data
);
`include "poisson_gauss_seidel_solver_top_defines.svh"
    localparam int AW = $clog2(GRID_MAX);

    logic [7:0]  grid_size_reg;
    logic [31:0] h_squared_reg;
    logic [30:0] tolerance_reg;
    logic [15:0] sweep_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg   <= 8'd128;
            h_squared_reg   <= 32'd262144;
            tolerance_reg   <= 31'd5243;
            sweep_limit_reg <= 16'd65535;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GRID_SIZE:   grid_size_reg   <= cfg_data[7:0];
                REG_H_SQUARED:   h_squared_reg   <= cfg_data;
                REG_TOLERANCE:   tolerance_reg   <= cfg_data[30:0];
                REG_SWEEP_LIMIT: sweep_limit_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    pgs_cmd_t  cmd;
    pgs_stat_t stat;
    logic out_load, in_fire, addr_ok;
    logic signed [31:0] rd_cell;
    logic [15:0] st_count;
    logic st_conv;
    logic [30:0] st_change;

    assign in_fire = s_valid && s_ready;
    // cells beyond the store: loads dropped, reads give zero
    assign addr_ok = (32'(s_row) < 32'(GRID_MAX)) && (32'(s_col) < 32'(GRID_MAX));

    pgs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_kind  (s_kind),
        .out_free (!m_valid || m_ready),
        .stat     (stat),
        .in_ready (s_ready),
        .out_load (out_load),
        .cmd      (cmd)
    );

    pgs_cmd_t dp_cmd;
    always_comb begin
        dp_cmd = cmd;
        dp_cmd.load_wr = cmd.load_wr && addr_ok;
    end

    logic addr_ok_reg;
    always_ff @(posedge aclk) begin
        if (in_fire) addr_ok_reg <= addr_ok;
    end

    pgs_datapath #(
        .GRID_MAX    (GRID_MAX),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (dp_cmd),
        .in_fire         (in_fire),
        .in_row          (AW'(s_row)),
        .in_col          (AW'(s_col)),
        .in_u            (s_u_value),
        .in_f            (s_f_value),
        .cfg_grid_size   (grid_size_reg),
        .cfg_h_squared   (h_squared_reg),
        .cfg_tolerance   (tolerance_reg),
        .cfg_sweep_limit (sweep_limit_reg),
        .stat            (stat),
        .rd_cell         (rd_cell),
        .st_count        (st_count),
        .st_conv         (st_conv),
        .st_change       (st_change)
    );

    // output register; the datapath registers the status fields on the load edge,
    // so payload is taken from the datapath after the load edge
    logic m_valid_reg, pend_reg, read_pend_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_reg <= 1'b0;
            read_pend_reg <= 1'b0;
        end else begin
            pend_reg <= out_load;
            read_pend_reg <= out_load && cmd.read_cap;
            if (pend_reg) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (pend_reg) begin
            m_cell_value   <= (read_pend_reg && !addr_ok_reg) ? 32'sd0 : rd_cell;
            m_sweep_count  <= st_count;
            m_converged    <= st_conv;
            m_final_change <= st_change;
        end
    end
    assign m_valid = m_valid_reg;

    // a presented result stays until the receiver takes it
    `PGS_ASSERT_NEXT(a_valid_held, aclk, aresetn, m_valid && !m_ready, m_valid,
                     "result dropped before acceptance")
    `PGS_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, pend_reg, !m_valid || m_ready,
                     "result loaded over unaccepted result")
    `PGS_ASSERT_NEXT(a_load_sets_valid, aclk, aresetn, pend_reg, m_valid,
                     "pending result not presented")
endmodule
`default_nettype wire
